@@ design/cre_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cre_pkg
// shared types and codes for the catmull-rom segment evaluator
// ----------------------------------------------------------------------------
package cre_pkg;

    // fixed field widths
    localparam int PT_W   = 32;   // control point, signed q16.16
    localparam int FRAC_W = 17;   // fraction, unsigned q1.16
    localparam int IDX_W  = 8;    // point index field
    localparam int CNT_W  = 9;    // point_count register
    localparam int ACC_W  = 40;   // horner accumulator, holds every step for t below two
    localparam int COEF_W = 36;   // c2 coefficient
    localparam int LIN_W  = 33;   // c1 and 2*p1

    // configuration register indexes
    localparam logic [0:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [0:0] CFG_LOOP_MODE   = 1'b1;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PAST_END = 2'd1,
        ST_TOO_FEW  = 2'd2
    } t_status;

    // term added after each multiply step
    typedef enum logic [1:0] {
        TERM_C2 = 2'd0,
        TERM_C1 = 2'd1,
        TERM_P1 = 2'd2
    } t_term;

    // sequencer to datapath controls
    typedef struct packed {
        logic  cap_frac;
        logic  cap_p0;
        logic  cap_p1;
        logic  cap_p2;
        logic  load_coef;
        logic  step;
        t_term term;
    } t_dp_cmd;

endpackage
`default_nettype wire

@@ design/cre_point_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cre_point_mem
// control point table, one write port and one registered read port
// ----------------------------------------------------------------------------
module cre_point_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    import cre_pkg::*;

    logic [PT_W-1:0] r_mem [DEPTH];
    logic [PT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/cre_horner.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cre_horner
// coefficient build and iterative horner evaluation on one shared multiplier
// ----------------------------------------------------------------------------
module cre_horner (
    input  logic             i_clk,
    input  cre_pkg::t_dp_cmd i_cmd,
    input  logic [16:0]      i_fraction,
    input  logic [31:0]      i_rd_data,
    output logic [31:0]      o_value
);
    import cre_pkg::*;

    logic        [FRAC_W-1:0]   r_t;
    logic signed [PT_W-1:0]     r_p0;
    logic signed [PT_W-1:0]     r_p1;
    logic signed [PT_W-1:0]     r_p2;
    logic signed [COEF_W-1:0]   r_c2;
    logic signed [LIN_W-1:0]    r_c1;
    logic signed [LIN_W-1:0]    r_p1x2;
    logic signed [ACC_W-1:0]    r_acc;

    logic signed [ACC_W-1:0]    w_e0, w_e1, w_e2, w_e3;
    logic signed [ACC_W-1:0]    w_c3, w_c2, w_c1, w_p1x2;
    logic signed [ACC_W+FRAC_W:0] w_prod;
    logic signed [ACC_W-1:0]    w_term;
    logic signed [ACC_W-1:0]    w_next;
    logic signed [ACC_W-1:0]    w_half;
    logic                       w_fits;

    // p3 is taken straight off the memory read data
    assign w_e0 = ACC_W'(r_p0);
    assign w_e1 = ACC_W'(r_p1);
    assign w_e2 = ACC_W'(r_p2);
    assign w_e3 = ACC_W'($signed(i_rd_data));

    assign w_c3   = w_e3 - w_e0 + (w_e1 <<< 1) + w_e1 - (w_e2 <<< 1) - w_e2;
    assign w_c2   = (w_e0 <<< 1) - (w_e1 <<< 2) - w_e1 + (w_e2 <<< 2) - w_e3;
    assign w_c1   = w_e2 - w_e0;
    assign w_p1x2 = w_e1 <<< 1;

    assign w_prod = r_acc * $signed({1'b0, r_t});

    always_comb begin
        case (i_cmd.term)
            TERM_C2: w_term = ACC_W'(r_c2);
            TERM_C1: w_term = ACC_W'(r_c1);
            TERM_P1: w_term = ACC_W'(r_p1x2);
            default: w_term = '0;
        endcase
    end

    // dropping the low 16 product bits rounds toward minus infinity
    assign w_next = $signed(w_prod[ACC_W+15:16]) + w_term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_frac) begin
            r_t <= i_fraction;
        end
        if (i_cmd.cap_p0) begin
            r_p0 <= $signed(i_rd_data);
        end
        if (i_cmd.cap_p1) begin
            r_p1 <= $signed(i_rd_data);
        end
        if (i_cmd.cap_p2) begin
            r_p2 <= $signed(i_rd_data);
        end
        if (i_cmd.load_coef) begin
            r_c2   <= COEF_W'(w_c2);
            r_c1   <= LIN_W'(w_c1);
            r_p1x2 <= LIN_W'(w_p1x2);
            r_acc  <= w_c3;
        end else if (i_cmd.step) begin
            r_acc <= w_next;
        end
    end

    // final halving and saturation to 32 bits
    assign w_half = r_acc >>> 1;
    assign w_fits = (&w_half[ACC_W-1:PT_W-1]) || !(|w_half[ACC_W-1:PT_W-1]);
    assign o_value = w_fits ? w_half[PT_W-1:0]
                   : (w_half[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

endmodule
`default_nettype wire

@@ design/catmull_rom_segment_evaluator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_segment_evaluator
// table of q16.16 control points with a uniform catmull-rom segment evaluator
// ----------------------------------------------------------------------------
// A write word (opcode write) stores one point; busy stays low, so writes
// can go every cycle. An evaluate word with fewer than two points or an
// index past the end gives its result in the cycle after it is taken. On the
// last segment without loop mode the last point is read back through the
// registered memory read and shown from the result register. Any other
// evaluate word keeps busy high until its result is shown: the four
// neighboring points come out of the single read port of the point memory
// one per cycle, then the coefficient state builds the coefficients, the
// three horner steps run through one shared 40x18 multiplier, and the
// saturate state halves and saturates. A new word may be started in the cycle
// in which a result is shown. Each result is on o_curve_value and o_status
// for exactly one cycle with o_valid high; the receiver cannot hold it off.
// The point memory is not cleared: reset leaves its contents unknown, and
// every point below point_count must be written before evaluating.
// ----------------------------------------------------------------------------
module catmull_rom_segment_evaluator #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command side
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [7:0]  i_point_index,
    input  logic [31:0] i_point_value,
    input  logic [16:0] i_fraction,
    // result side
    output logic        o_valid,
    output logic [31:0] o_curve_value,
    output logic [1:0]  o_status,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);
    import cre_pkg::*;

    // memory address width and width of index arithmetic
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = ($clog2(MAX_POINTS + 1) > CNT_W) ? $clog2(MAX_POINTS + 1) : CNT_W;
    localparam logic [NW-1:0] CAP = NW'(MAX_POINTS);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RD1  = 10'b00_0000_0010,
        S_RD2  = 10'b00_0000_0100,
        S_RD3  = 10'b00_0000_1000,
        S_COEF = 10'b00_0001_0000,
        S_MUL1 = 10'b00_0010_0000,
        S_MUL2 = 10'b00_0100_0000,
        S_MUL3 = 10'b00_1000_0000,
        S_SAT  = 10'b01_0000_0000,
        S_LAST = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [CNT_W-1:0] r_point_count;
    logic             r_loop_mode;

    // neighbor indexes of the segment in progress
    logic [NW-1:0] r_i1, r_i2, r_i3;

    // result register
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_curve, n_curve;
    t_status       r_status, n_status;

    // word decode
    logic          w_take, w_write, w_eval;
    logic [NW-1:0] w_idx, w_cnt, w_n, w_end;
    logic [NW-1:0] w_i0, w_i2a, w_i2, w_i3;
    logic          w_few, w_past, w_wrap, w_last;

    // memory and datapath
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rd_data;
    logic [31:0]   w_dp_value;
    t_dp_cmd       w_cmd;

    assign w_take  = start && !busy;
    assign w_write = w_take && (i_opcode == OP_WRITE);
    assign w_eval  = w_take && (i_opcode == OP_EVAL);

    // count in use, limited to the table size
    assign w_idx  = NW'(i_point_index);
    assign w_cnt  = NW'(r_point_count);
    assign w_n    = (w_cnt > CAP) ? CAP : w_cnt;
    assign w_end  = w_n - NW'(1);
    assign w_few  = w_n < NW'(2);
    assign w_past = w_idx >= w_n;

    // first segment takes the last point as p0 when looping, else p1 itself
    assign w_i0 = (w_idx == '0) ? (r_loop_mode ? w_end : '0) : (w_idx - NW'(1));

    // last segment wraps to points zero and one, or is the plain last point
    assign w_i2a  = w_idx + NW'(1);
    assign w_wrap = (w_i2a == w_n);
    assign w_last = w_wrap && !r_loop_mode;
    assign w_i2   = w_wrap ? '0 : w_i2a;
    assign w_i3   = (w_i2a == w_end) ? (r_loop_mode ? '0 : w_end)
                  : (w_wrap ? NW'(1) : (w_i2a + NW'(1)));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_loop_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data;
                CFG_LOOP_MODE:   r_loop_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_eval && !w_few && !w_past) begin
                    n_state = w_last ? S_LAST : S_RD1;
                end
            end
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_COEF;
            S_COEF:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_SAT;
            S_SAT:   n_state = S_IDLE;
            S_LAST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_i1 <= w_idx;
            r_i2 <= w_i2;
            r_i3 <= w_i3;
        end
    end

    // read address: p0 (or the last point) is read in the accept cycle
    always_comb begin
        case (r_state)
            S_RD1:   w_raddr = AW'(r_i1);
            S_RD2:   w_raddr = AW'(r_i2);
            S_RD3:   w_raddr = AW'(r_i3);
            default: w_raddr = w_last ? AW'(w_end) : AW'(w_i0);
        endcase
    end

    cre_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_write && (w_idx < CAP)),
        .i_waddr (AW'(w_idx)),
        .i_wdata (i_point_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_data)
    );

    // datapath controls follow the read sequence
    always_comb begin
        w_cmd.cap_frac  = w_eval;
        w_cmd.cap_p0    = (r_state == S_RD1);
        w_cmd.cap_p1    = (r_state == S_RD2);
        w_cmd.cap_p2    = (r_state == S_RD3);
        w_cmd.load_coef = (r_state == S_COEF);
        w_cmd.step      = (r_state == S_MUL1) || (r_state == S_MUL2) || (r_state == S_MUL3);
        case (r_state)
            S_MUL2:  w_cmd.term = TERM_C1;
            S_MUL3:  w_cmd.term = TERM_P1;
            default: w_cmd.term = TERM_C2;
        endcase
    end

    cre_horner u_horner (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_fraction (i_fraction),
        .i_rd_data  (w_rd_data),
        .o_value    (w_dp_value)
    );

    // result register, one word per evaluate
    always_comb begin
        n_out_valid = 1'b0;
        n_curve     = r_curve;
        n_status    = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_eval && (w_few || w_past)) begin
                    n_out_valid = 1'b1;
                    n_curve     = '0;
                    n_status    = w_few ? ST_TOO_FEW : ST_PAST_END;
                end
            end
            S_LAST: begin
                n_out_valid = 1'b1;
                n_curve     = w_rd_data;
                n_status    = ST_OK;
            end
            S_SAT: begin
                n_out_valid = 1'b1;
                n_curve     = w_dp_value;
                n_status    = ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_curve  <= n_curve;
        r_status <= n_status;
    end

    assign o_valid       = r_out_valid;
    assign o_curve_value = r_curve;
    assign o_status      = r_status;

endmodule
`default_nettype wire

@@ design/cre_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cre_checker
// port-level checks on the catmull-rom segment evaluator
// ----------------------------------------------------------------------------
module cre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic        o_valid,
    input logic [31:0] o_curve_value,
    input logic [1:0]  o_status
);
    import cre_pkg::*;

    // a result is only shown once the sequencer is back at rest
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // error results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_curve_value == 32'h0))
        else $error("error result with nonzero value");

    // a point write never produces a result word
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_WRITE) |=> !o_valid)
        else $error("result after a point write");

    // an evaluate either starts work or answers at once
    a_eval_followup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_EVAL) |=> (busy || o_valid))
        else $error("evaluate word dropped");

endmodule

bind catmull_rom_segment_evaluator cre_checker u_cre_checker (.*);
`default_nettype wire

@@ tb/catmull_rom_segment_evaluator_test.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_segment_evaluator_test
// self-checking bench for the catmull-rom segment evaluator
// ----------------------------------------------------------------------------
// A short directed plan covers the register extremes, both opcodes, the
// status codes, and the end handling of clamp and wrap modes. Then come random
// phases, each with its own point count and loop setting. Each phase fills
// every slot in use before it evaluates anything. A bit-exact model of the
// horner datapath predicts each result word not written in by hand, and each
// o_valid word is compared field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module catmull_rom_segment_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cre_pkg::*;

    localparam int N_SLOTS     = 256;
    localparam int RANDOM_GOAL = 2000;
    localparam int QUIET_AFTER = 1700;   // no gaps once this many random words went in
    localparam int SETTLE      = 12;     // wait after the last result word, longer than any evaluate

    // one predicted result word
    typedef struct {
        logic [31:0] value;
        t_status     st;
    } t_curve;

    // directed plan: register writes and command words in one list
    typedef enum bit {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [0:0]  reg_idx;
        logic [8:0]  reg_data;
        t_opcode     op;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [16:0] frac;
        bit          typed;      // expected word written in by hand
        logic [31:0] want_val;
        t_status     want_st;
    } t_plan_row;

    // dut signals
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [7:0]  i_point_index;
    logic [31:0] i_point_value;
    logic [16:0] i_fraction;
    logic        o_valid;
    logic [31:0] o_curve_value;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [8:0]  i_cfg_data;

    // shadow of the block's state
    logic [31:0] pts_shadow [N_SLOTS];
    bit          pts_written [N_SLOTS];
    logic [8:0]  cfg_count;
    logic        cfg_loop;

    t_curve pending_curves[$];
    t_curve want;

    int mismatches;
    int eval_count;
    int write_count;
    int phase_count;
    int seen_ok;
    int seen_past_end;
    int seen_too_few;

    catmull_rom_segment_evaluator #(
        .MAX_POINTS(N_SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_point_index(i_point_index),
        .i_point_value(i_point_value),
        .i_fraction   (i_fraction),
        .o_valid      (o_valid),
        .o_curve_value(o_curve_value),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        #(5_000_000);
        $display("timeout waiting for result words");
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // horner evaluation in q16.16, every shift rounds toward minus infinity
    function automatic void predict_curve(input logic [7:0] idx, input logic [16:0] frac,
                                          output logic [31:0] value, output t_status st);
        int     n, last, j0, j1, j2, j3;
        longint q0, q1, q2, q3, c3, c2, c1, acc, t;
        n     = (cfg_count > N_SLOTS) ? N_SLOTS : int'(cfg_count);
        value = '0;
        st    = ST_OK;
        if (n < 2) begin
            st = ST_TOO_FEW;
            return;
        end
        j1 = int'(idx);
        if (j1 >= n) begin
            st = ST_PAST_END;
            return;
        end
        last = n - 1;
        // first segment: wrap to the last point or clamp to itself
        if (j1 == 0)
            j0 = cfg_loop ? last : 0;
        else
            j0 = j1 - 1;
        j2 = j1 + 1;
        if (j2 == last) begin
            j3 = cfg_loop ? 0 : last;
        end else if (j2 == n) begin
            // last segment: clamp mode just hands back the last point
            if (!cfg_loop) begin
                value = pts_shadow[last];
                return;
            end
            j2 = 0;
            j3 = 1;
        end else begin
            j3 = j2 + 1;
        end
        q0  = $signed(pts_shadow[j0]);
        q1  = $signed(pts_shadow[j1]);
        q2  = $signed(pts_shadow[j2]);
        q3  = $signed(pts_shadow[j3]);
        t   = longint'(frac);
        c3  = -q0 + 3 * q1 - 3 * q2 + q3;
        c2  = 2 * q0 - 5 * q1 + 4 * q2 - q3;
        c1  = q2 - q0;
        acc = c3;
        acc = ((acc * t) >>> 16) + c2;
        acc = ((acc * t) >>> 16) + c1;
        acc = ((acc * t) >>> 16) + 2 * q1;
        acc = acc >>> 1;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        value = acc[31:0];
    endfunction

    // result side: every o_valid word must match the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_curves.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %h status %0d",
                                          o_curve_value, o_status));
            end else begin
                want = pending_curves.pop_front();
                if (o_curve_value !== want.value)
                    report_mismatch($sformatf("curve_value %h, want %h",
                                              o_curve_value, want.value));
                if (o_status !== want.st)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.st));
                case (o_status)
                    ST_OK:       seen_ok++;
                    ST_PAST_END: seen_past_end++;
                    ST_TOO_FEW:  seen_too_few++;
                    default:     ;
                endcase
            end
        end
    end

    // drive one word and hold it until the block takes it; returns at a falling
    // edge with start still high, so back-to-back words keep start asserted
    task automatic send_word(input t_opcode op, input logic [7:0] idx,
                             input logic [31:0] val, input logic [16:0] frac,
                             input bit typed = 1'b0, input logic [31:0] want_val = '0,
                             input t_status want_st = ST_OK);
        t_curve c;
        bit     taken;
        start         = 1'b1;
        i_opcode      = op;
        i_point_index = idx;
        i_point_value = val;
        i_fraction    = frac;
        taken         = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        if (op == OP_WRITE) begin
            pts_shadow[idx]  = val;
            pts_written[idx] = 1'b1;
            write_count++;
        end else begin
            if (typed) begin
                c.value = want_val;
                c.st    = want_st;
            end else begin
                predict_curve(idx, frac, c.value, c.st);
            end
            pending_curves.push_back(c);
            eval_count++;
        end
        @(negedge i_clk);
    endtask

    // sender gap with junk on the fields
    task automatic idle_for(input int cycles);
        start         = 1'b0;
        i_opcode      = 1'($urandom);
        i_point_index = 8'($urandom);
        i_point_value = $urandom;
        i_fraction    = 17'($urandom);
        repeat (cycles) @(negedge i_clk);
    endtask

    // wait for every predicted word, then let a possible write finish
    task automatic drain_results();
        start = 1'b0;
        while (pending_curves.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [8:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == CFG_POINT_COUNT)
            cfg_count = data;
        else
            cfg_loop = data[0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // empty row with every field set
    function automatic t_plan_row blank_row();
        t_plan_row r;
        r.kind     = ROW_WORD;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.op       = OP_WRITE;
        r.idx      = '0;
        r.val      = '0;
        r.frac     = '0;
        r.typed    = 1'b0;
        r.want_val = '0;
        r.want_st  = ST_OK;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [0:0] idx, input logic [8:0] data);
        t_plan_row r;
        r          = blank_row();
        r.kind     = ROW_CFG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_plan_row wr_row(input logic [7:0] idx, input logic [31:0] val);
        t_plan_row r;
        r      = blank_row();
        r.kind = ROW_WORD;
        r.op   = OP_WRITE;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_plan_row ev_row(input logic [7:0] idx, input logic [16:0] frac);
        t_plan_row r;
        r      = blank_row();
        r.kind = ROW_WORD;
        r.op   = OP_EVAL;
        r.idx  = idx;
        r.val  = $urandom;
        r.frac = frac;
        return r;
    endfunction

    function automatic t_plan_row ev_chk(input logic [7:0] idx, input logic [16:0] frac,
                                         input logic [31:0] val, input t_status st);
        t_plan_row r;
        r          = ev_row(idx, frac);
        r.typed    = 1'b1;
        r.want_val = val;
        r.want_st  = st;
        return r;
    endfunction

    // point values lean on the extremes and on modest curves
    function automatic logic [31:0] rand_point();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(0, 200 << 16) - (100 << 16);
            default: return $urandom;
        endcase
    endfunction

    // fractions: mostly inside the segment, some at the ends, some beyond one
    function automatic logic [16:0] rand_fraction();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;
            3:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        t_plan_row plan[$];
        t_plan_row r;
        int        random_words;
        int        n_eff;
        int        steps;
        int        pick;
        int        idx;
        bit        quiet;
        bit        gappy;
        logic [8:0] cnt;
        logic       lm;

        // every input known from time zero
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_WRITE;
        i_point_index = '0;
        i_point_value = '0;
        i_fraction    = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_POINT_COUNT;
        i_cfg_data    = '0;
        cfg_count     = '0;
        cfg_loop      = 1'b0;
        foreach (pts_written[s]) pts_written[s] = 1'b0;
        foreach (pts_shadow[s]) pts_shadow[s] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // too few points: nothing in use after reset, then just one
        plan.push_back(cfg_row(CFG_LOOP_MODE, 9'd0));
        plan.push_back(ev_chk(8'd0, 17'd0, 32'd0, ST_TOO_FEW));
        plan.push_back(cfg_row(CFG_POINT_COUNT, 9'd1));
        plan.push_back(ev_chk(8'd255, 17'h1FFFF, 32'd0, ST_TOO_FEW));
        // four points, the first two at the value extremes
        plan.push_back(cfg_row(CFG_POINT_COUNT, 9'd4));
        plan.push_back(wr_row(8'd0, 32'h7FFF_FFFF));
        plan.push_back(wr_row(8'd1, 32'h8000_0000));
        plan.push_back(wr_row(8'd2, 32'h0001_0000));
        plan.push_back(wr_row(8'd3, 32'hFFFF_0000));
        plan.push_back(wr_row(8'd255, 32'h1234_5678));
        plan.push_back(ev_chk(8'd4, 17'd100, 32'd0, ST_PAST_END));
        plan.push_back(ev_chk(8'd255, 17'd0, 32'd0, ST_PAST_END));
        // clamp mode: last segment hands back the last point
        plan.push_back(ev_chk(8'd3, 17'd777, 32'hFFFF_0000, ST_OK));
        // t of zero lands on p1, t of one on p2
        plan.push_back(ev_chk(8'd0, 17'd0, 32'h7FFF_FFFF, ST_OK));
        plan.push_back(ev_chk(8'd1, 17'd65536, 32'h0001_0000, ST_OK));
        plan.push_back(ev_row(8'd2, 17'h1FFFF));
        plan.push_back(ev_row(8'd1, 17'd32768));
        // loop mode: wrap on every end
        plan.push_back(cfg_row(CFG_LOOP_MODE, 9'd1));
        plan.push_back(ev_chk(8'd3, 17'd0, 32'hFFFF_0000, ST_OK));
        plan.push_back(ev_row(8'd3, 17'd40000));
        plan.push_back(ev_row(8'd0, 17'd20000));
        plan.push_back(ev_row(8'd2, 17'd50000));
        // two points, the smallest usable curve
        plan.push_back(cfg_row(CFG_POINT_COUNT, 9'd2));
        plan.push_back(cfg_row(CFG_LOOP_MODE, 9'd0));
        plan.push_back(ev_row(8'd0, 17'd30000));
        plan.push_back(ev_chk(8'd1, 17'd12345, 32'h8000_0000, ST_OK));
        plan.push_back(cfg_row(CFG_LOOP_MODE, 9'd1));
        plan.push_back(ev_row(8'd1, 17'd45000));

        foreach (plan[k]) begin
            r = plan[k];
            if (r.kind == ROW_CFG) begin
                drain_results();
                set_reg(r.reg_idx, r.reg_data);
            end else begin
                send_word(r.op, r.idx, r.val, r.frac, r.typed, r.want_val, r.want_st);
            end
        end

        // random phases, the first few pinned to the count extremes
        random_words = 0;
        while (random_words < RANDOM_GOAL) begin
            case (phase_count)
                0:       cnt = 9'd2;
                1:       cnt = 9'd3;
                2:       cnt = 9'd256;
                3:       cnt = 9'd511;
                4:       cnt = 9'd0;
                5:       cnt = 9'd1;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        cnt = 9'($urandom_range(2, 12));
                    else if (pick < 9)
                        cnt = 9'($urandom_range(13, 255));
                    else
                        cnt = 9'($urandom_range(256, 511));
                end
            endcase
            lm    = (phase_count < 6) ? phase_count[0] : 1'($urandom);
            gappy = ($urandom_range(0, 3) != 0);
            phase_count++;

            drain_results();
            set_reg(CFG_POINT_COUNT, cnt);
            // upper data bits are don't care for the loop flag
            set_reg(CFG_LOOP_MODE, {8'($urandom), lm});
            n_eff = (cnt > N_SLOTS) ? N_SLOTS : int'(cnt);

            // every slot in use must hold a point before any evaluate reads it
            for (int s = 0; s < n_eff; s++) begin
                if (!pts_written[s] || $urandom_range(0, 3) == 0) begin
                    send_word(OP_WRITE, 8'(s), rand_point(), 17'($urandom));
                    random_words++;
                end
            end

            steps = $urandom_range(40, 140);
            repeat (steps) begin
                quiet = (random_words >= QUIET_AFTER);
                if ($urandom_range(0, 9) < 6) begin
                    if (n_eff < 2) begin
                        idx = $urandom_range(0, 255);
                    end else begin
                        case ($urandom_range(0, 9))
                            0:       idx = 0;
                            1:       idx = n_eff - 1;
                            2:       idx = n_eff - 2;
                            3:       idx = $urandom_range(0, 255);
                            default: idx = $urandom_range(0, n_eff - 1);
                        endcase
                    end
                    send_word(OP_EVAL, 8'(idx), $urandom, rand_fraction());
                end else begin
                    send_word(OP_WRITE, 8'($urandom), rand_point(), 17'($urandom));
                end
                random_words++;
                if (!quiet && gappy && $urandom_range(0, 4) == 0)
                    idle_for($urandom_range(1, 11));
                if (!quiet && $urandom_range(0, 39) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("ran %0d evaluate words and %0d point writes over %0d random settings",
                 eval_count, write_count, phase_count);
        $display("results seen: %0d ok, %0d past end, %0d too few",
                 seen_ok, seen_past_end, seen_too_few);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/cre_pkg.sv
design/cre_point_mem.sv
design/cre_horner.sv
design/catmull_rom_segment_evaluator.sv
design/cre_checker.sv
tb/catmull_rom_segment_evaluator_test.sv
